[sv/assert_macros.svh]
// Assertion macros used by pgs_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[sv/pgs_pkg.sv]
// Types, constants and arithmetic helpers of the path smoother
package pgs_pkg;

    localparam int COORD_W = 24;
    localparam int HEAD_W  = 16;
    localparam int WGT_W   = 16;
    localparam int TOL_W   = 24;
    localparam int SUM_W   = 32;
    localparam int FRAC_W  = 16;
    localparam int CFG_W   = 24;
    localparam int CFG_IDX_W = 2;
    localparam int MUL_A_W = COORD_W + 2;
    localparam int PROD_W  = MUL_A_W + WGT_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_DATA_WGT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_SMOOTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE     = 2'd2;

    localparam logic [WGT_W-1:0] DATA_WGT_RST      = 16'd6554;
    localparam logic [WGT_W-1:0] WEIGHT_SMOOTH_RST = 16'd29491;
    localparam logic [TOL_W-1:0] TOLERANCE_RST     = 24'd13;

    localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
    localparam logic signed [PROD_W-1:0] SAT_LO = -SAT_HI - PROD_W'(1);
    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(64'sd1 <<< (FRAC_W - 1));

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [HEAD_W-1:0]  heading;
    } pgs_point_t;

    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [PROD_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > SAT_HI)
        begin
            r = SAT_HI[COORD_W-1:0];
        end
        else if (v < SAT_LO)
        begin
            r = SAT_LO[COORD_W-1:0];
        end
        else
        begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

    // round to nearest, halves up, by arithmetic shift
    function automatic logic signed [PROD_W-1:0] round_q16(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] s;
        s = p + RND_HALF;
        return s >>> FRAC_W;
    endfunction

endpackage

[sv/pgs_job_fifo.sv]
// Two-entry queue of path jobs between front and back
module pgs_job_fifo
    import pgs_pkg::*;
#(
    parameter int W = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic         not_empty,
    output logic [W-1:0] pop_data
);

    logic [W-1:0] mem_reg [2];
    logic         wp_reg, wp_next;
    logic         rp_reg, rp_next;
    logic [1:0]   cnt_reg, cnt_next;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign pop_data  = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push && !full)
        begin
            wp_next = ~wp_reg;
        end
        if (pop && not_empty)
        begin
            rp_next = ~rp_reg;
        end
        cnt_next = cnt_reg + 2'((push && !full) ? 1 : 0) - 2'((pop && not_empty) ? 1 : 0);
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wp_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

[sv/pgs_front.sv]
// Point loader: counts points, flags overflow, issues one job per path
module pgs_front
    import pgs_pkg::*;
#(
    parameter int MAX_POINTS = 64,
    parameter int AW = 6,
    parameter int CNT_W = 7
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      pt_valid,
    output logic                      pt_ready,
    input  logic signed [COORD_W-1:0] pos_x,
    input  logic signed [COORD_W-1:0] pos_y,
    input  logic signed [HEAD_W-1:0]  heading,
    input  logic                      last_point,
    input  logic                      job_done,
    input  logic                      job_full,
    output logic                      wr_en,
    output logic [AW-1:0]             wr_addr,
    output pgs_point_t                wr_pt,
    output logic                      job_push,
    output logic [CNT_W-1:0]          job_n,
    output logic                      job_ovf
);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;
    logic             wait_reg, wait_next;
    logic             beat;
    logic             room;

    assign pt_ready = !wait_reg && !job_full;
    assign beat     = pt_valid && pt_ready;
    assign room     = (cnt_reg < CNT_W'(MAX_POINTS));

    assign wr_en      = beat && room;
    assign wr_addr    = cnt_reg[AW-1:0];
    assign wr_pt.x    = pos_x;
    assign wr_pt.y    = pos_y;
    assign wr_pt.heading = heading;
    assign job_push   = beat && last_point;
    assign job_n      = room ? cnt_reg + CNT_W'(1) : cnt_reg;
    assign job_ovf    = ovf_reg || !room;

    always_comb
    begin
        cnt_next  = cnt_reg;
        ovf_next  = ovf_reg;
        wait_next = wait_reg;
        if (job_done)
        begin
            wait_next = 1'b0;
        end
        if (beat)
        begin
            if (last_point)
            begin
                cnt_next  = '0;
                ovf_next  = 1'b0;
                wait_next = 1'b1;
            end
            else
            begin
                cnt_next = job_n;
                ovf_next = job_ovf;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            ovf_reg  <= 1'b0;
            wait_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            ovf_reg  <= ovf_next;
            wait_reg <= wait_next;
        end
    end

endmodule

[sv/pgs_back.sv]
// Point stores, sweep engine and result emitter
`include "assert_macros.svh"
module pgs_back
    import pgs_pkg::*;
#(
    parameter int MAX_POINTS = 64,
    parameter int MAX_SWEEPS = 1024,
    parameter int AW = 6,
    parameter int CNT_W = 7
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [WGT_W-1:0]          data_wgt,
    input  logic [WGT_W-1:0]          weight_smooth,
    input  logic [TOL_W-1:0]          tolerance,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  pgs_point_t                wr_pt,
    input  logic                      job_avail,
    input  logic [CNT_W-1:0]          job_n,
    input  logic                      job_ovf,
    output logic                      job_pop,
    output logic                      job_done,
    output logic                      res_valid,
    input  logic                      res_ready,
    output logic signed [COORD_W-1:0] out_x,
    output logic signed [COORD_W-1:0] out_y,
    output logic signed [HEAD_W-1:0]  out_heading,
    output logic                      end_of_path,
    output logic                      sweep_cap_hit,
    output logic                      points_dropped
);

    localparam int SWP_W = $clog2(MAX_SWEEPS + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_START, ST_PREV, ST_CUR, ST_NEXT, ST_MUL1, ST_ADD1, ST_MUL2,
        ST_ADD2, ST_WR, ST_ADV, ST_E_RD, ST_E_LD, ST_E_WAIT
    } state_t;

    logic signed [COORD_W-1:0] orig_x_mem [MAX_POINTS];
    logic signed [COORD_W-1:0] orig_y_mem [MAX_POINTS];
    logic signed [COORD_W-1:0] work_x_mem [MAX_POINTS];
    logic signed [COORD_W-1:0] work_y_mem [MAX_POINTS];
    logic signed [HEAD_W-1:0]  head_mem   [MAX_POINTS];

    logic [AW-1:0] w_rd_addr, o_rd_addr;
    logic signed [COORD_W-1:0] wq_x, wq_y, oq_x, oq_y;
    logic signed [HEAD_W-1:0]  hq;
    logic                      bw_en;
    logic [AW-1:0]             bw_addr;

    state_t state_reg, state_next;
    logic signed [COORD_W-1:0] prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    logic signed [COORD_W-1:0] cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic signed [COORD_W-1:0] nxt_x_reg, nxt_x_next, nxt_y_reg, nxt_y_next;
    logic signed [COORD_W-1:0] org_x_reg, org_x_next, org_y_reg, org_y_next;
    logic signed [COORD_W-1:0] new_x_reg, new_x_next, new_y_reg, new_y_next;
    logic signed [COORD_W-1:0] c1_reg, c1_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic                      axis_reg, axis_next;
    logic [AW-1:0]             idx_reg, idx_next;
    logic [CNT_W-1:0]          n_reg, n_next;
    logic [CNT_W-1:0]          k_reg, k_next;
    logic [SWP_W-1:0]          swp_reg, swp_next;
    logic [SUM_W-1:0]          sum_reg, sum_next;
    logic                      ovf_reg, ovf_next;
    logic                      cap_reg, cap_next;
    logic                      rv_reg, rv_next;
    logic signed [COORD_W-1:0] ox_reg, ox_next, oy_reg, oy_next;
    logic signed [HEAD_W-1:0]  oh_reg, oh_next;
    logic                      eop_reg, eop_next;

    logic signed [COORD_W-1:0] cur_a, org_a, prev_a, nxt_a, nv;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [WGT_W:0]     mul_b;
    logic signed [COORD_W:0]   mv_s;
    logic [COORD_W:0]          mv;
    logic [SUM_W:0]            sum_w;
    logic [CNT_W:0]            idx_p2;
    logic                      above;

    assign cur_a  = axis_reg ? cur_y_reg  : cur_x_reg;
    assign org_a  = axis_reg ? org_y_reg  : org_x_reg;
    assign prev_a = axis_reg ? prev_y_reg : prev_x_reg;
    assign nxt_a  = axis_reg ? nxt_y_reg  : nxt_x_reg;

    always_comb
    begin
        if (state_reg == ST_MUL2)
        begin
            mul_a = MUL_A_W'(prev_a) + MUL_A_W'(nxt_a) - (MUL_A_W'(c1_reg) <<< 1);
            mul_b = $signed({1'b0, weight_smooth});
        end
        else
        begin
            mul_a = MUL_A_W'(org_a) - MUL_A_W'(cur_a);
            mul_b = $signed({1'b0, data_wgt});
        end
    end

    assign nv    = sat_coord(PROD_W'(c1_reg) + round_q16(prod_reg));
    assign mv_s  = (COORD_W + 1)'(cur_a) - (COORD_W + 1)'(nv);
    assign mv    = mv_s[COORD_W] ? (COORD_W + 1)'(-mv_s) : mv_s;
    assign sum_w = {1'b0, sum_reg} + (SUM_W + 1)'(mv);
    assign idx_p2 = (CNT_W + 1)'(idx_reg) + (CNT_W + 1)'(2);
    assign above = (sum_reg >= SUM_W'(tolerance));

    assign bw_en   = (state_reg == ST_WR);
    assign bw_addr = idx_reg;

    always_comb
    begin
        w_rd_addr = idx_reg;
        o_rd_addr = idx_reg;
        case (state_reg)
            ST_START: w_rd_addr = '0;
            ST_PREV:
            begin
                w_rd_addr = AW'(1);
                o_rd_addr = AW'(1);
            end
            ST_CUR:  w_rd_addr = AW'(2);
            ST_WR:
            begin
                w_rd_addr = idx_p2[AW-1:0];
                o_rd_addr = idx_reg + AW'(1);
            end
            ST_E_RD: w_rd_addr = k_reg[AW-1:0];
            default: w_rd_addr = idx_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            orig_x_mem[wr_addr] <= wr_pt.x;
            orig_y_mem[wr_addr] <= wr_pt.y;
            head_mem[wr_addr]   <= wr_pt.heading;
        end
        if (wr_en)
        begin
            work_x_mem[wr_addr] <= wr_pt.x;
            work_y_mem[wr_addr] <= wr_pt.y;
        end
        else if (bw_en)
        begin
            work_x_mem[bw_addr] <= new_x_reg;
            work_y_mem[bw_addr] <= new_y_reg;
        end
        wq_x <= work_x_mem[w_rd_addr];
        wq_y <= work_y_mem[w_rd_addr];
        hq   <= head_mem[w_rd_addr];
        oq_x <= orig_x_mem[o_rd_addr];
        oq_y <= orig_y_mem[o_rd_addr];
    end

    assign job_pop  = (state_reg == ST_IDLE) && job_avail;
    assign job_done = (job_pop && (job_n == '0))
                   || ((state_reg == ST_E_WAIT) && res_ready && eop_reg);

    always_comb
    begin
        state_next  = state_reg;
        prev_x_next = prev_x_reg;
        prev_y_next = prev_y_reg;
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        nxt_x_next  = nxt_x_reg;
        nxt_y_next  = nxt_y_reg;
        org_x_next  = org_x_reg;
        org_y_next  = org_y_reg;
        new_x_next  = new_x_reg;
        new_y_next  = new_y_reg;
        c1_next     = c1_reg;
        prod_next   = prod_reg;
        axis_next   = axis_reg;
        idx_next    = idx_reg;
        n_next      = n_reg;
        k_next      = k_reg;
        swp_next    = swp_reg;
        sum_next    = sum_reg;
        ovf_next    = ovf_reg;
        cap_next    = cap_reg;
        rv_next     = rv_reg;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        oh_next     = oh_reg;
        eop_next    = eop_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (job_avail)
                begin
                    n_next   = job_n;
                    ovf_next = job_ovf;
                    swp_next = '0;
                    cap_next = 1'b0;
                    k_next   = '0;
                    if (job_n == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (job_n < CNT_W'(3))
                    begin
                        state_next = ST_E_RD;
                    end
                    else
                    begin
                        state_next = ST_START;
                    end
                end
            end
            ST_START:
            begin
                sum_next   = '0;
                state_next = ST_PREV;
            end
            ST_PREV:
            begin
                prev_x_next = wq_x;
                prev_y_next = wq_y;
                state_next  = ST_CUR;
            end
            ST_CUR:
            begin
                cur_x_next = wq_x;
                cur_y_next = wq_y;
                org_x_next = oq_x;
                org_y_next = oq_y;
                state_next = ST_NEXT;
            end
            ST_NEXT:
            begin
                nxt_x_next = wq_x;
                nxt_y_next = wq_y;
                idx_next   = AW'(1);
                axis_next  = 1'b0;
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                prod_next  = PROD_W'(mul_a * mul_b);
                state_next = ST_ADD1;
            end
            ST_ADD1:
            begin
                c1_next    = sat_coord(PROD_W'(cur_a) + round_q16(prod_reg));
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                prod_next  = PROD_W'(mul_a * mul_b);
                state_next = ST_ADD2;
            end
            ST_ADD2:
            begin
                if (axis_reg)
                begin
                    new_y_next = nv;
                    state_next = ST_WR;
                end
                else
                begin
                    new_x_next = nv;
                    state_next = ST_MUL1;
                end
                axis_next = ~axis_reg;
                sum_next  = sum_w[SUM_W] ? '1 : sum_w[SUM_W-1:0];
            end
            ST_WR:
            begin
                prev_x_next = new_x_reg;
                prev_y_next = new_y_reg;
                cur_x_next  = nxt_x_reg;
                cur_y_next  = nxt_y_reg;
                if (idx_p2 < (CNT_W + 1)'(n_reg))
                begin
                    state_next = ST_ADV;
                end
                else
                begin
                    swp_next = swp_reg + SWP_W'(1);
                    if (above && ((swp_reg + SWP_W'(1)) < SWP_W'(MAX_SWEEPS)))
                    begin
                        state_next = ST_START;
                    end
                    else
                    begin
                        cap_next   = above;
                        k_next     = '0;
                        state_next = ST_E_RD;
                    end
                end
            end
            ST_ADV:
            begin
                org_x_next = oq_x;
                org_y_next = oq_y;
                nxt_x_next = wq_x;
                nxt_y_next = wq_y;
                idx_next   = idx_reg + AW'(1);
                state_next = ST_MUL1;
            end
            ST_E_RD:
            begin
                state_next = ST_E_LD;
            end
            ST_E_LD:
            begin
                ox_next    = wq_x;
                oy_next    = wq_y;
                oh_next    = hq;
                eop_next   = (k_reg == n_reg - CNT_W'(1));
                rv_next    = 1'b1;
                state_next = ST_E_WAIT;
            end
            ST_E_WAIT:
            begin
                if (res_ready)
                begin
                    rv_next = 1'b0;
                    k_next  = k_reg + CNT_W'(1);
                    state_next = eop_reg ? ST_IDLE : ST_E_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rv_reg    <= 1'b0;
            swp_reg   <= '0;
            sum_reg   <= '0;
            n_reg     <= '0;
            k_reg     <= '0;
            ovf_reg   <= 1'b0;
            cap_reg   <= 1'b0;
            eop_reg   <= 1'b0;
            axis_reg  <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rv_reg    <= rv_next;
            swp_reg   <= swp_next;
            sum_reg   <= sum_next;
            n_reg     <= n_next;
            k_reg     <= k_next;
            ovf_reg   <= ovf_next;
            cap_reg   <= cap_next;
            eop_reg   <= eop_next;
            axis_reg  <= axis_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_x_reg <= prev_x_next;
        prev_y_reg <= prev_y_next;
        cur_x_reg  <= cur_x_next;
        cur_y_reg  <= cur_y_next;
        nxt_x_reg  <= nxt_x_next;
        nxt_y_reg  <= nxt_y_next;
        org_x_reg  <= org_x_next;
        org_y_reg  <= org_y_next;
        new_x_reg  <= new_x_next;
        new_y_reg  <= new_y_next;
        c1_reg     <= c1_next;
        prod_reg   <= prod_next;
        ox_reg     <= ox_next;
        oy_reg     <= oy_next;
        oh_reg     <= oh_next;
    end

    assign res_valid      = rv_reg;
    assign out_x          = ox_reg;
    assign out_y          = oy_reg;
    assign out_heading    = oh_reg;
    assign end_of_path    = eop_reg;
    assign sweep_cap_hit  = cap_reg;
    assign points_dropped = ovf_reg;

    `ASSERT_IMPLIES(a_valid_only_emit, res_valid, state_reg == ST_E_WAIT)
    `ASSERT_IMPLIES(a_sweep_bound, 1'b1, swp_reg <= SWP_W'(MAX_SWEEPS))
    `ASSERT_NEXT(a_last_beat_idle, res_valid && res_ready && end_of_path, state_reg == ST_IDLE)
    `ASSERT_IMPLIES(a_no_write_clash, wr_en, state_reg == ST_IDLE)

endmodule

[sv/path_gradient_smoother.sv]
// Top level of the path smoother: config registers, loader, job queue, sweep engine
//
//  channel | signals                                       | handshake
//  points  | pos_x pos_y heading last_point                | pt_valid / pt_ready
//  results | out_x out_y out_heading end_of_path ...       | res_valid / res_ready
//  config  | cfg_index cfg_data                            | cfg_we, no wait
//
// Points load one per cycle. After the last point the back end pops the job,
// then each sweep relaxes the inner points (one shared multiplier, x then y),
// repeated until the movement sum drops below tolerance or MAX_SWEEPS; results
// then leave one at a time. The loader stalls from the last point until the
// path is out. Reset is asynchronous; point stores need no clearing.
module path_gradient_smoother
    import pgs_pkg::*;
#(
    parameter int MAX_POINTS = 64,
    parameter int MAX_SWEEPS = 1024
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]          cfg_data,
    input  logic                      pt_valid,
    output logic                      pt_ready,
    input  logic signed [COORD_W-1:0] pos_x,
    input  logic signed [COORD_W-1:0] pos_y,
    input  logic signed [HEAD_W-1:0]  heading,
    input  logic                      last_point,
    output logic                      res_valid,
    input  logic                      res_ready,
    output logic signed [COORD_W-1:0] out_x,
    output logic signed [COORD_W-1:0] out_y,
    output logic signed [HEAD_W-1:0]  out_heading,
    output logic                      end_of_path,
    output logic                      sweep_cap_hit,
    output logic                      points_dropped
);

    localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    logic [WGT_W-1:0] wd_reg, ws_reg;
    logic [TOL_W-1:0] tol_reg;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    pgs_point_t       wr_pt;
    logic             job_push, job_full, job_pop, job_avail, job_done;
    logic [CNT_W-1:0] f_n, b_n;
    logic             f_ovf, b_ovf;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wd_reg  <= DATA_WGT_RST;
            ws_reg  <= WEIGHT_SMOOTH_RST;
            tol_reg <= TOLERANCE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DATA_WGT:      wd_reg  <= cfg_data[WGT_W-1:0];
                REG_WEIGHT_SMOOTH: ws_reg  <= cfg_data[WGT_W-1:0];
                REG_TOLERANCE:     tol_reg <= cfg_data[TOL_W-1:0];
                default:           tol_reg <= tol_reg;
            endcase
        end
    end

    pgs_front #(.MAX_POINTS(MAX_POINTS), .AW(AW), .CNT_W(CNT_W)) u_front (
        .clk(clk), .rst_n(rst_n),
        .pt_valid(pt_valid), .pt_ready(pt_ready),
        .pos_x(pos_x), .pos_y(pos_y), .heading(heading), .last_point(last_point),
        .job_done(job_done), .job_full(job_full),
        .wr_en(wr_en), .wr_addr(wr_addr), .wr_pt(wr_pt),
        .job_push(job_push), .job_n(f_n), .job_ovf(f_ovf)
    );

    pgs_job_fifo #(.W(CNT_W + 1)) u_fifo (
        .clk(clk), .rst_n(rst_n),
        .push(job_push), .push_data({f_n, f_ovf}), .full(job_full),
        .pop(job_pop), .not_empty(job_avail), .pop_data({b_n, b_ovf})
    );

    pgs_back #(.MAX_POINTS(MAX_POINTS), .MAX_SWEEPS(MAX_SWEEPS), .AW(AW), .CNT_W(CNT_W))
    u_back (
        .clk(clk), .rst_n(rst_n),
        .data_wgt(wd_reg), .weight_smooth(ws_reg), .tolerance(tol_reg),
        .wr_en(wr_en), .wr_addr(wr_addr), .wr_pt(wr_pt),
        .job_avail(job_avail), .job_n(b_n), .job_ovf(b_ovf),
        .job_pop(job_pop), .job_done(job_done),
        .res_valid(res_valid), .res_ready(res_ready),
        .out_x(out_x), .out_y(out_y), .out_heading(out_heading),
        .end_of_path(end_of_path), .sweep_cap_hit(sweep_cap_hit),
        .points_dropped(points_dropped)
    );

endmodule

[tb/sv/tb.sv]
// Testbench for path_gradient_smoother: random paths checked against a built-in smoothing predictor
`timescale 1ns / 100ps
module tb;
    import pgs_pkg::*;

    localparam int  NPTS      = 64;
    localparam int  NSWEEPS   = 1024;
    localparam int  WDOG_MAX  = 3000000;
    localparam int  SETTLE    = 40;
    localparam int  HOLD_LEN  = 600;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [HEAD_W-1:0]  h;
        logic                      last;
    } point_beat_t;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [HEAD_W-1:0]  h;
        logic                      eop;
        logic                      cap;
        logic                      drop;
    } smoothed_pt_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_W-1:0]          cfg_data;
    logic                      pt_valid;
    logic                      pt_ready;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [HEAD_W-1:0]  heading;
    logic                      last_point;
    logic                      res_valid;
    logic                      res_ready;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [HEAD_W-1:0]  out_heading;
    logic                      end_of_path;
    logic                      sweep_cap_hit;
    logic                      points_dropped;

    path_gradient_smoother dut (.*);

    point_beat_t  pending_pts[$];
    smoothed_pt_t expected_pts[$];

    // predictor state
    longint       orig_x[NPTS];
    longint       orig_y[NPTS];
    longint       work_x[NPTS];
    longint       work_y[NPTS];
    longint       head_st[NPTS];
    int           stored_cnt;
    bit           overflow_flag;
    longint       w_data;
    longint       w_smooth;
    longint       tol;

    int           mismatches;
    int           send_idle_pct;
    int           recv_stall_pct;
    bit           hold_arm;
    int           hold_left;
    int           quiet_cycles;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic longint clamp_coord(longint v);
        longint hi;
        hi = (64'sd1 <<< (COORD_W - 1)) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    function automatic longint weighted_step(longint d, longint w);
        longint p;
        p = d * w + 32768;
        if (p >= 0)
            return p / 65536;
        return -((-p + 65535) / 65536);
    endfunction

    function automatic longint relax_coord(longint cur, longint org, longint prv, longint nxt);
        longint c;
        c = clamp_coord(cur + weighted_step(org - cur, w_data));
        c = clamp_coord(c + weighted_step(prv + nxt - 2 * c, w_smooth));
        return c;
    endfunction

    function automatic longint add_movement(longint total, longint a, longint b);
        longint s;
        s = total + ((a > b) ? a - b : b - a);
        return (s > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : s;
    endfunction

    task automatic smooth_path(input int n, output bit cap);
        longint sum;
        longint px;
        longint py;
        int     sweeps;
        sum = 0;
        sweeps = 0;
        cap = 1'b0;
        if (n >= 3)
        begin
            do
            begin
                sum = 0;
                for (int i = 1; i + 1 < n; i++)
                begin
                    px = work_x[i];
                    py = work_y[i];
                    work_x[i] = relax_coord(px, orig_x[i], work_x[i-1], work_x[i+1]);
                    work_y[i] = relax_coord(py, orig_y[i], work_y[i-1], work_y[i+1]);
                    sum = add_movement(sum, px, work_x[i]);
                    sum = add_movement(sum, py, work_y[i]);
                end
                sweeps++;
            end
            while (sum >= tol && sweeps < NSWEEPS);
            cap = (sum >= tol);
        end
    endtask

    task automatic take_point(input point_beat_t b);
        smoothed_pt_t r;
        bit           cap;
        if (stored_cnt < NPTS)
        begin
            orig_x[stored_cnt] = b.x;
            orig_y[stored_cnt] = b.y;
            work_x[stored_cnt] = b.x;
            work_y[stored_cnt] = b.y;
            head_st[stored_cnt] = b.h;
            stored_cnt++;
        end
        else
            overflow_flag = 1'b1;
        if (b.last)
        begin
            smooth_path(stored_cnt, cap);
            for (int k = 0; k < stored_cnt; k++)
            begin
                r.x    = work_x[k][COORD_W-1:0];
                r.y    = work_y[k][COORD_W-1:0];
                r.h    = head_st[k][HEAD_W-1:0];
                r.eop  = (k + 1 == stored_cnt);
                r.cap  = cap;
                r.drop = overflow_flag;
                expected_pts = {expected_pts, r};
            end
            stored_cnt = 0;
            overflow_flag = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        mismatches++;
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
            pt_valid <= 1'b0;
        else if (!pt_valid || pt_ready)
        begin
            if (pt_valid)
                take_point('{pos_x, pos_y, heading, last_point});
            if (pending_pts.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                point_beat_t b;
                b = pending_pts.pop_front();
                pt_valid   <= 1'b1;
                pos_x      <= b.x;
                pos_y      <= b.y;
                heading    <= b.h;
                last_point <= b.last;
            end
            else
                pt_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        smoothed_pt_t e;
        if (!rst_n)
            res_ready <= 1'b0;
        else
        begin
            if (res_valid && res_ready)
            begin
                if (expected_pts.size() == 0)
                    report_mismatch("unexpected beat", out_x, 0);
                else
                begin
                    e = expected_pts.pop_front();
                    if (out_x !== e.x)
                        report_mismatch("out_x", out_x, e.x);
                    if (out_y !== e.y)
                        report_mismatch("out_y", out_y, e.y);
                    if (out_heading !== e.h)
                        report_mismatch("out_heading", out_heading, e.h);
                    if (end_of_path !== e.eop)
                        report_mismatch("end_of_path", end_of_path, e.eop);
                    if (sweep_cap_hit !== e.cap)
                        report_mismatch("sweep_cap_hit", sweep_cap_hit, e.cap);
                    if (points_dropped !== e.drop)
                        report_mismatch("points_dropped", points_dropped, e.drop);
                end
            end
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                res_ready <= 1'b0;
            end
            else if (hold_arm && res_valid)
            begin
                hold_arm  <= 1'b0;
                hold_left <= HOLD_LEN;
                res_ready <= 1'b0;
            end
            else
                res_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((pt_valid && pt_ready) || (res_valid && res_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX)
        begin
            $display("watchdog: no beat for %0d cycles", WDOG_MAX);
            $display("status: fail");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_DATA_WGT:      w_data   = val[WGT_W-1:0];
            REG_WEIGHT_SMOOTH: w_smooth = val[WGT_W-1:0];
            REG_TOLERANCE:     tol      = val[TOL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_weights(input int wd, input int ws, input int tl);
        write_reg(REG_DATA_WGT, CFG_W'(wd));
        write_reg(REG_WEIGHT_SMOOTH, CFG_W'(ws));
        write_reg(REG_TOLERANCE, CFG_W'(tl));
    endtask

    task automatic push_point(input longint x, input longint y, input longint h, input bit last);
        point_beat_t b;
        b.x    = x[COORD_W-1:0];
        b.y    = y[COORD_W-1:0];
        b.h    = h[HEAD_W-1:0];
        b.last = last;
        pending_pts = {pending_pts, b};
    endtask

    // style 0: random walk, 1: arbitrary coordinates, 2: near the rails
    task automatic queue_path(input int len, input int style);
        longint x;
        longint y;
        x = longint'($signed(24'($urandom))) >>> 3;
        y = longint'($signed(24'($urandom))) >>> 3;
        for (int i = 0; i < len; i++)
        begin
            case (style)
                0:
                begin
                    x = clamp_coord(x + $urandom_range(4096) - 2048);
                    y = clamp_coord(y + $urandom_range(4096) - 2048);
                end
                1:
                begin
                    x = $signed(24'($urandom));
                    y = $signed(24'($urandom));
                end
                default:
                begin
                    x = $urandom_range(1) ? 8388607 - $urandom_range(15) : -8388608 + $urandom_range(15);
                    y = $urandom_range(1) ? 8388607 - $urandom_range(15) : -8388608 + $urandom_range(15);
                end
            endcase
            push_point(x, y, $signed(16'($urandom)), i == len - 1);
        end
    endtask

    task automatic drain;
        while (pending_pts.size() > 0 || pt_valid)
            @(posedge clk);
        while (expected_pts.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic random_paths(input int n_items, input int max_len);
        int left;
        int len;
        int r;
        left = n_items;
        while (left > 0)
        begin
            len = $urandom_range(max_len, 1);
            if (len > left)
                len = left;
            r = $urandom_range(9);
            queue_path(len, (r < 6) ? 0 : (r < 9) ? 1 : 2);
            left -= len;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        pt_valid = 1'b0;
        pos_x = '0;
        pos_y = '0;
        heading = '0;
        last_point = 1'b0;
        res_ready = 1'b0;
        mismatches = 0;
        stored_cnt = 0;
        overflow_flag = 1'b0;
        w_data = DATA_WGT_RST;
        w_smooth = WEIGHT_SMOOTH_RST;
        tol = TOLERANCE_RST;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_arm = 1'b0;
        hold_left = 0;
        quiet_cycles = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset weights
        push_point(8388607, -8388608, -32768, 1'b1);
        push_point(-8388608, 8388607, 32767, 1'b0);
        push_point(100, -100, 0, 1'b1);
        push_point(-8388608, -8388608, 1, 1'b0);
        push_point(8388607, 8388607, -1, 1'b0);
        push_point(-8388608, -8388608, 4096, 1'b1);
        push_point(8388607, -8388608, -4096, 1'b0);
        push_point(-8388608, 8388607, 0, 1'b0);
        push_point(-8388608, 8388607, 0, 1'b0);
        push_point(8388607, -8388608, 0, 1'b1);
        queue_path(6, 0);
        drain();

        // full store: straight line, last two points dropped
        for (int i = 0; i < NPTS + 2; i++)
            push_point(i * 256, -i * 128, i, i == NPTS + 1);
        drain();

        // one sweep only, pure data pull
        set_weights(65535, 0, 24'hFFFFFF);
        send_idle_pct = 60;
        random_paths(25, 8);
        drain();

        // zero tolerance hits the sweep cap on paths of three or more points; keep paths short
        set_weights(0, 65535, 0);
        send_idle_pct = 0;
        recv_stall_pct = 60;
        queue_path(3, 1);
        queue_path(4, 0);
        queue_path(2, 1);
        drain();

        set_weights(DATA_WGT_RST, WEIGHT_SMOOTH_RST, TOLERANCE_RST);
        send_idle_pct = 8;
        recv_stall_pct = 8;
        random_paths(30, 12);
        drain();

        // receiver holds off while the sender keeps offering paths
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_arm = 1'b1;
        queue_path(4, 0);
        queue_path(5, 1);
        queue_path(4, 0);
        drain();

        set_weights($urandom_range(65535), $urandom_range(40000), $urandom_range(400));
        send_idle_pct = 60;
        random_paths(15, 10);
        drain();
        send_idle_pct = 0;
        recv_stall_pct = 60;
        random_paths(15, 10);
        drain();

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

[sim.f]
+incdir+sv
sv/pgs_pkg.sv
sv/pgs_job_fifo.sv
sv/pgs_front.sv
sv/pgs_back.sv
sv/path_gradient_smoother.sv
tb/sv/tb.sv
